// ----- src/button_press_classifier_macros.svh -----
// -----------------------------------------------------------------------------
// button press classifier assertion macros
// shared assertion forms for the checker
// -----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bpc_pkg.sv -----
// -----------------------------------------------------------------------------
// bpc_pkg
// types, constants and helpers shared by the button press classifier
// -----------------------------------------------------------------------------
package bpc_pkg;

	localparam int TIME_W = 16;
	localparam int CFG_W  = 16;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [CFG_W-1:0]  cfg_ms_t;

	localparam logic [32:0] TIME_MAX_X = (33'd1 << TIME_W) - 33'd1;

	localparam cfg_ms_t DEBOUNCE_RST   = cfg_ms_t'(100);
	localparam cfg_ms_t LONG_PRESS_RST = cfg_ms_t'(0);
	localparam logic    IDLE_LEVEL_RST = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_IDLE_LEVEL = 2'd2
	} reg_idx_t;

	typedef enum logic [5:0] {
		PH_IDLE     = 6'b000001,
		PH_PRESS_DB = 6'b000010,
		PH_HELD     = 6'b000100,
		PH_CLASSIFY = 6'b001000,
		PH_LOAD_REL = 6'b010000,
		PH_REL_DB   = 6'b100000
	} phase_t;

	typedef struct packed {
		cfg_ms_t debounce_ms;
		cfg_ms_t long_press_ms;
		logic    idle_level;
	} cfg_t;

	// timer load value, clamped to the timer range
	function automatic time_t load_timer(input cfg_ms_t v);
		logic [32:0] vx;
		vx = {{(33-CFG_W){1'b0}}, v};
		if (vx > TIME_MAX_X) begin
			return '1;
		end
		return time_t'(vx);
	endfunction

endpackage

// ----- src/bpc_fsm.sv -----
// -----------------------------------------------------------------------------
// bpc_fsm
// press/release debounce state machine with press length counter
// -----------------------------------------------------------------------------
module bpc_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  bpc_pkg::cfg_t     cfg,
	output bpc_pkg::event_t   ev
);

	bpc_pkg::phase_t phase_q, phase_d;
	bpc_pkg::time_t  dleft_q, dleft_d, dleft_dec;
	bpc_pkg::time_t  ticks_q, ticks_d, ticks_inc;
	logic            pressed;
	logic            counting;

	assign pressed   = (level != cfg.idle_level);
	assign counting  = (phase_q == bpc_pkg::PH_PRESS_DB) || (phase_q == bpc_pkg::PH_HELD)
		|| (phase_q == bpc_pkg::PH_CLASSIFY);
	assign dleft_dec = (dleft_q != '0) ? dleft_q - bpc_pkg::time_t'(1) : dleft_q;
	assign ticks_inc = (counting && (ticks_q != '1)) ? ticks_q + bpc_pkg::time_t'(1) : ticks_q;

	always_comb begin
		phase_d = phase_q;
		dleft_d = dleft_dec;
		ticks_d = ticks_inc;
		ev      = bpc_pkg::EV_NONE;
		unique case (phase_q)
			bpc_pkg::PH_IDLE: begin
				if (pressed) begin
					dleft_d = bpc_pkg::load_timer(cfg.debounce_ms);
					ticks_d = '0;
					phase_d = bpc_pkg::PH_PRESS_DB;
				end
			end
			bpc_pkg::PH_PRESS_DB: begin
				if (dleft_dec == '0) begin
					phase_d = pressed ? bpc_pkg::PH_HELD : bpc_pkg::PH_CLASSIFY;
				end
			end
			bpc_pkg::PH_HELD: begin
				if (!pressed) begin
					phase_d = bpc_pkg::PH_CLASSIFY;
				end
			end
			bpc_pkg::PH_CLASSIFY: begin
				if ({{(33-bpc_pkg::TIME_W){1'b0}}, ticks_inc}
					> {{(33-bpc_pkg::CFG_W){1'b0}}, cfg.long_press_ms}) begin
					ev = bpc_pkg::EV_LONG;
				end else begin
					ev = bpc_pkg::EV_SHORT;
				end
				phase_d = bpc_pkg::PH_LOAD_REL;
			end
			bpc_pkg::PH_LOAD_REL: begin
				dleft_d = bpc_pkg::load_timer(cfg.debounce_ms);
				phase_d = bpc_pkg::PH_REL_DB;
			end
			bpc_pkg::PH_REL_DB: begin
				if (dleft_dec == '0) begin
					phase_d = bpc_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = bpc_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpc_pkg::PH_IDLE;
			dleft_q <= '0;
			ticks_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			dleft_q <= dleft_d;
			ticks_q <= ticks_d;
		end
	end

endmodule

// ----- src/button_press_classifier.sv -----
// -----------------------------------------------------------------------------
// button_press_classifier
// debounced button classifier reporting none, short or long press per tick
// -----------------------------------------------------------------------------
// One tick word is taken per cycle while tick_ready is high; its result is
// offered once it heads the output buffer. The state update (debounce timer,
// press counter, phase) completes within the accepting cycle. A two-entry
// output buffer lets ticks keep flowing while one result waits; tick_ready
// drops only when both entries are full. Registers sit on the APB port at
// byte addresses 0x0 (debounce_ms), 0x4 (long_press_ms) and 0x8 (idle_level).
module button_press_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_ready,
	input  logic                              pin_level,
	output logic                              event_valid,
	input  logic                              event_ready,
	output logic [1:0]                        press_event,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bpc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [bpc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bpc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	bpc_pkg::cfg_t   cfg_q;
	bpc_pkg::event_t ev_d;
	logic [1:0]      head_q, skid_q;
	logic            head_valid_q, skid_valid_q;
	logic            push, pop, wr_en;

	// configuration
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= bpc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms <= bpc_pkg::LONG_PRESS_RST;
			cfg_q.idle_level    <= bpc_pkg::IDLE_LEVEL_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				bpc_pkg::REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[bpc_pkg::CFG_W-1:0];
				bpc_pkg::REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[bpc_pkg::CFG_W-1:0];
				bpc_pkg::REG_IDLE_LEVEL: cfg_q.idle_level    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			bpc_pkg::REG_DEBOUNCE:   prdata[bpc_pkg::CFG_W-1:0] = cfg_q.debounce_ms;
			bpc_pkg::REG_LONG_PRESS: prdata[bpc_pkg::CFG_W-1:0] = cfg_q.long_press_ms;
			bpc_pkg::REG_IDLE_LEVEL: prdata[0] = cfg_q.idle_level;
			default:                 prdata = '0;
		endcase
	end

	// classifier
	assign tick_ready = !skid_valid_q;
	assign push       = tick_valid && tick_ready;
	assign pop        = event_valid && event_ready;

	bpc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (push),
		.level  (pin_level),
		.cfg    (cfg_q),
		.ev     (ev_d)
	);

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop && skid_valid_q) begin
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			head_valid_q <= push;
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			head_q <= skid_q;
		end else if (push && (pop || !head_valid_q)) begin
			head_q <= ev_d;
		end else if (push) begin
			skid_q <= ev_d;
		end
	end

	assign event_valid = head_valid_q;
	assign press_event = head_q;

endmodule

// ----- src/bpc_checker.sv -----
// -----------------------------------------------------------------------------
// bpc_checker
// port-level checks for the button press classifier
// -----------------------------------------------------------------------------
`include "button_press_classifier_macros.svh"

module bpc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              tick_valid,
	input logic                              tick_ready,
	input logic                              event_valid,
	input logic                              event_ready,
	input logic [1:0]                        press_event
);

	`BPC_ASSERT_NOW(a_event_code, event_valid, press_event != 2'd3, "bad press_event code")
	`BPC_ASSERT_NOW(a_stall_only_full, !tick_ready, event_valid, "tick stalled with no word")
	`BPC_ASSERT_NEXT(a_tick_to_word, tick_valid && tick_ready && !event_valid, event_valid, "accepted tick gave no word")
	`BPC_ASSERT_NEXT(a_word_holds, event_valid && !event_ready, event_valid && $stable(press_event), "word dropped or changed while stalled")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

// ----- tb/sv/button_press_classifier_checker.sv -----
// -----------------------------------------------------------------------------
// button_press_classifier_checker
// watches the tick, event and register ports, runs its own copy of the press
// classifier on every accepted tick word and compares each event word with
// the oldest prediction; register reads are checked against the shadow copy
// -----------------------------------------------------------------------------
module button_press_classifier_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	input  logic                           tick_ready,
	input  logic                           pin_level,
	input  logic                           event_valid,
	input  logic                           event_ready,
	input  logic [1:0]                     press_event,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bpc_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [bpc_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	bpc_pkg::cfg_t   shadow_cfg;
	bpc_pkg::phase_t cur_phase;
	bpc_pkg::time_t  db_left;
	bpc_pkg::time_t  press_cnt;
	bpc_pkg::event_t pending_events[$];
	int              errors = 0;

	always @(posedge clk or negedge arst_n) begin
		logic                           pressed;
		bpc_pkg::time_t                 load_val;
		bpc_pkg::event_t                outcome;
		bpc_pkg::event_t                oldest;
		logic [bpc_pkg::APB_DATA_W-1:0] reg_exp;
		logic                           reg_known;
		if (!arst_n) begin
			shadow_cfg.debounce_ms   = bpc_pkg::DEBOUNCE_RST;
			shadow_cfg.long_press_ms = bpc_pkg::LONG_PRESS_RST;
			shadow_cfg.idle_level    = bpc_pkg::IDLE_LEVEL_RST;
			cur_phase = bpc_pkg::PH_IDLE;
			db_left   = '0;
			press_cnt = '0;
			pending_events.delete();
		end else begin
			if (psel && penable && pready && !pwrite) begin
				reg_known = 1'b1;
				case (bpc_pkg::reg_idx_t'(paddr[3:2]))
				bpc_pkg::REG_DEBOUNCE: begin
					reg_exp = bpc_pkg::APB_DATA_W'(shadow_cfg.debounce_ms);
				end
				bpc_pkg::REG_LONG_PRESS: begin
					reg_exp = bpc_pkg::APB_DATA_W'(shadow_cfg.long_press_ms);
				end
				bpc_pkg::REG_IDLE_LEVEL: begin
					reg_exp = bpc_pkg::APB_DATA_W'(shadow_cfg.idle_level);
				end
				default: begin
					reg_exp = '0;
					reg_known = 1'b0;
				end
				endcase
				if (reg_known && prdata !== reg_exp) begin
					$display("%0t: prdata mismatch at 0x%0h, expected 0x%0h, actual 0x%0h",
						$time, paddr, reg_exp, prdata);
					errors++;
				end
			end

			if (psel && penable && pready && pwrite) begin
				case (bpc_pkg::reg_idx_t'(paddr[3:2]))
				bpc_pkg::REG_DEBOUNCE: begin
					shadow_cfg.debounce_ms = pwdata[bpc_pkg::CFG_W-1:0];
				end
				bpc_pkg::REG_LONG_PRESS: begin
					shadow_cfg.long_press_ms = pwdata[bpc_pkg::CFG_W-1:0];
				end
				bpc_pkg::REG_IDLE_LEVEL: begin
					shadow_cfg.idle_level = pwdata[0];
				end
				default: begin
				end
				endcase
			end

			if (tick_valid && tick_ready) begin
				pressed = (pin_level != shadow_cfg.idle_level);
				outcome = bpc_pkg::EV_NONE;
				// clamp for a timer narrower than the register
				load_val = (longint'(shadow_cfg.debounce_ms) >
					((longint'(1) << bpc_pkg::TIME_W) - 1)) ?
					'1 : bpc_pkg::time_t'(shadow_cfg.debounce_ms);
				if (db_left != '0) begin
					db_left = db_left - 1'b1;
				end
				if ((cur_phase == bpc_pkg::PH_PRESS_DB || cur_phase == bpc_pkg::PH_HELD ||
						cur_phase == bpc_pkg::PH_CLASSIFY) && press_cnt != '1) begin
					press_cnt = press_cnt + 1'b1;
				end
				case (cur_phase)
				bpc_pkg::PH_IDLE: begin
					if (pressed) begin
						db_left   = load_val;
						press_cnt = '0;
						cur_phase = bpc_pkg::PH_PRESS_DB;
					end
				end
				bpc_pkg::PH_PRESS_DB: begin
					if (db_left == '0) begin
						cur_phase = pressed ? bpc_pkg::PH_HELD : bpc_pkg::PH_CLASSIFY;
					end
				end
				bpc_pkg::PH_HELD: begin
					if (!pressed) begin
						cur_phase = bpc_pkg::PH_CLASSIFY;
					end
				end
				bpc_pkg::PH_CLASSIFY: begin
					outcome = (press_cnt > shadow_cfg.long_press_ms) ?
						bpc_pkg::EV_LONG : bpc_pkg::EV_SHORT;
					cur_phase = bpc_pkg::PH_LOAD_REL;
				end
				bpc_pkg::PH_LOAD_REL: begin
					db_left   = load_val;
					cur_phase = bpc_pkg::PH_REL_DB;
				end
				bpc_pkg::PH_REL_DB: begin
					if (db_left == '0) begin
						cur_phase = bpc_pkg::PH_IDLE;
					end
				end
				default: begin
					cur_phase = bpc_pkg::PH_IDLE;
				end
				endcase
				pending_events.push_back(outcome);
			end

			if (event_valid && event_ready) begin
				if (pending_events.size() == 0) begin
					$display("%0t: unexpected press_event word, expected none, actual %0d",
						$time, press_event);
					errors++;
				end else begin
					oldest = pending_events.pop_front();
					if (press_event !== oldest) begin
						$display("%0t: press_event mismatch, expected %0d, actual %0d",
							$time, oldest, press_event);
						errors++;
					end
				end
			end
		end
		outstanding <= pending_events.size();
		fail_count  <= errors;
	end

endmodule

// ----- tb/sv/button_press_classifier_tb.sv -----
// -----------------------------------------------------------------------------
// button_press_classifier_tb
// drives tick words and register writes into the press classifier: a short
// directed run, then random press traffic under changing settings with bursty
// input and a stalling event receiver; the checker beside the block does all
// the comparing
// -----------------------------------------------------------------------------
module button_press_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT = 100_000;
	localparam logic [1:0] REG_UNUSED  = 2'd3;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           tick_valid = 1'b0;
	logic                           tick_ready;
	logic                           pin_level = 1'b0;
	logic                           event_valid;
	logic                           event_ready = 1'b0;
	logic [1:0]                     press_event;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [bpc_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [bpc_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [bpc_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	int                             fail_count;
	int                             outstanding;

	logic                           want_long_stall = 1'b0;
	int                             ticks_sent = 0;
	int                             burst_left = 0;
	bit                             sender_gaps = 1'b1;
	logic                           cur_idle = bpc_pkg::IDLE_LEVEL_RST;
	int                             cur_db = int'(bpc_pkg::DEBOUNCE_RST);
	longint                         cycle_count = 0;

	always #4 clk = ~clk;

	button_press_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_ready  (tick_ready),
		.pin_level   (pin_level),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.press_event (press_event),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	button_press_classifier_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_ready  (tick_ready),
		.pin_level   (pin_level),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.press_event (press_event),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("button_press_classifier verification failed");
			$finish;
		end
	end

	// event receiver with its own stall pattern and one long hold-off
	always @(posedge clk) begin
		static int       stall_left = 0;
		static int       mode_left = 0;
		static int       rx_count = 0;
		static bit       long_stall_done = 1'b0;
		static rx_mode_t rx_mode = RX_ALWAYS;
		rx_count++;
		if (want_long_stall && !long_stall_done) begin
			long_stall_done = 1'b1;
			stall_left = 400;
		end
		if (stall_left != 0) begin
			stall_left--;
			event_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (rx_mode)
			RX_ALWAYS: begin
				event_ready <= 1'b1;
			end
			RX_COIN: begin
				event_ready <= 1'($urandom_range(0, 1));
			end
			RX_SPARSE: begin
				event_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				event_ready <= (rx_count % 3 != 0);
			end
			endcase
		end
	end

	task automatic send_tick(input logic lvl);
		int gap;
		tick_valid <= 1'b1;
		pin_level  <= lvl;
		@(posedge clk);
		while (!tick_ready) @(posedge clk);
		ticks_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = sender_gaps ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [1:0] idx,
			input logic [bpc_pkg::APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= bpc_pkg::APB_ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input bpc_pkg::cfg_ms_t db, input bpc_pkg::cfg_ms_t lp,
			input logic idle);
		reg_access(1'b1, bpc_pkg::REG_DEBOUNCE,
			($urandom() & 32'hFFFF_0000) | bpc_pkg::APB_DATA_W'(db));
		reg_access(1'b1, bpc_pkg::REG_LONG_PRESS,
			($urandom() & 32'hFFFF_0000) | bpc_pkg::APB_DATA_W'(lp));
		reg_access(1'b1, bpc_pkg::REG_IDLE_LEVEL,
			($urandom() & 32'hFFFF_FFFE) | bpc_pkg::APB_DATA_W'(idle));
		if ($urandom_range(0, 2) == 0) begin
			reg_access(1'b1, REG_UNUSED, $urandom());
		end
		reg_access(1'b0, bpc_pkg::REG_DEBOUNCE, '0);
		reg_access(1'b0, bpc_pkg::REG_LONG_PRESS, '0);
		reg_access(1'b0, bpc_pkg::REG_IDLE_LEVEL, '0);
		cur_db   = int'(db);
		cur_idle = idle;
	endtask

	// mostly clean presses with random timing, some bounce and pure noise
	task automatic press_traffic(input int n_items);
		int stop_at;
		int hold_len;
		int rel_len;
		stop_at = ticks_sent + n_items;
		while (ticks_sent < stop_at) begin
			case ($urandom_range(0, 9))
			0: begin
				repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
			end
			default: begin
				repeat ($urandom_range(0, 5)) send_tick(cur_idle);
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(0, 1)));
				end
				hold_len = $urandom_range(1, cur_db + 30);
				repeat (hold_len) send_tick(~cur_idle);
				rel_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) :
					cur_db + $urandom_range(2, 5);
				repeat (rel_len) send_tick(cur_idle);
			end
			endcase
		end
	endtask

	initial begin
		bpc_pkg::cfg_ms_t db;
		bpc_pkg::cfg_ms_t lp;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values
		reg_access(1'b0, bpc_pkg::REG_DEBOUNCE, '0);
		reg_access(1'b0, bpc_pkg::REG_LONG_PRESS, '0);
		reg_access(1'b0, bpc_pkg::REG_IDLE_LEVEL, '0);
		reg_access(1'b0, REG_UNUSED, '0);

		// zero debounce, every press long, early release
		set_config(16'd0, 16'd0, 1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		drain();

		// idle low: early release in the debounce, then a held press
		set_config(16'd2, 16'd3, 1'b0);
		send_tick(1'b1);
		repeat (5) send_tick(1'b0);
		repeat (8) send_tick(1'b1);
		repeat (5) send_tick(1'b0);
		drain();

		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(0, 3))
			0: db = 16'd0;
			1: db = 16'd1;
			default: db = bpc_pkg::cfg_ms_t'($urandom_range(2, 10));
			endcase
			case ($urandom_range(0, 5))
			0: lp = 16'd0;
			1: lp = 16'hFFFF;
			default: lp = bpc_pkg::cfg_ms_t'($urandom_range(1, 24));
			endcase
			set_config(db, lp, 1'($urandom_range(0, 1)));
			sender_gaps = ($urandom_range(0, 2) != 0);
			if (p == 3) begin
				want_long_stall <= 1'b1;
				sender_gaps = 1'b0;
			end
			press_traffic(72);
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("button_press_classifier verification clean");
		end else begin
			$display("button_press_classifier verification failed");
		end
		$finish;
	end

endmodule

// ----- button_press_classifier.f -----
+incdir+src
src/bpc_pkg.sv
src/bpc_fsm.sv
src/button_press_classifier.sv
src/bpc_checker.sv
tb/sv/button_press_classifier_checker.sv
tb/sv/button_press_classifier_tb.sv
